// ===== rtl/aes_cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// AES-128 CBC package
// Shared types, register indexes and byte functions of the cipher core.
// ----------------------------------------------------------------------------
package aes_cbc_pkg;

    typedef struct packed {
        logic [63:0] block_in_high;
        logic [63:0] block_in_low;
        logic        first_block;
    } in_word_t;

    typedef struct packed {
        logic [63:0] block_out_high;
        logic [63:0] block_out_low;
    } out_word_t;

    typedef struct packed {
        logic         start;
        logic         decrypt;
        logic [127:0] state;
    } round_cmd_t;

    localparam logic [2:0] REG_KEY_HIGH = 3'd0;
    localparam logic [2:0] REG_KEY_LOW  = 3'd1;
    localparam logic [2:0] REG_IV_HIGH  = 3'd2;
    localparam logic [2:0] REG_IV_LOW   = 3'd3;
    localparam logic [2:0] REG_DECRYPT  = 3'd4;

    localparam int NUM_ROUNDS = 10;
    localparam int NUM_WORDS  = 44;

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_shift(input logic [7:0] a, input int n);
        logic [7:0] v;
        v = a;
        for (int i = 0; i < 7; i++) begin
            if (i < n) v = xtime(v);
        end
        return v;
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] t;
        p = 8'h00;
        t = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ t;
            t = xtime(t);
        end
        return p;
    endfunction

    function automatic logic [7:0] gf_inverse(input logic [7:0] a);
        logic [7:0] r;
        logic [7:0] b;
        logic [7:0] p;
        r = 8'h01;
        b = a;
        // a^254 by square and multiply
        for (int e = 1; e < 8; e++) begin
            p = 8'h00;
            for (int i = 0; i < 8; i++) begin
                if (b[i]) p = p ^ gf_shift(b, i);
            end
            b = p;
            r = gf_mul(r, b);
        end
        return r;
    endfunction

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] x;
        x = gf_inverse(a);
        return x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]}
               ^ {x[3:0], x[7:4]} ^ 8'h63;
    endfunction

    function automatic logic [7:0] inv_sbox(input logic [7:0] a);
        logic [7:0] y;
        y = {a[6:0], a[7]} ^ {a[4:0], a[7:5]} ^ {a[1:0], a[7:2]} ^ 8'h05;
        return gf_inverse(y);
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
        logic [7:0] s [4];
        logic [7:0] m [4];
        logic [31:0] r;
        for (int k = 0; k < 4; k++) s[k] = c[31-8*k -: 8];
        if (inv) begin
            m[0] = 8'h0e; m[1] = 8'h0b; m[2] = 8'h0d; m[3] = 8'h09;
        end else begin
            m[0] = 8'h02; m[1] = 8'h03; m[2] = 8'h01; m[3] = 8'h01;
        end
        for (int row = 0; row < 4; row++) begin
            r[31-8*row -: 8] = gf_mul(m[(4-row)%4], s[0]) ^ gf_mul(m[(5-row)%4], s[1])
                             ^ gf_mul(m[(6-row)%4], s[2]) ^ gf_mul(m[(7-row)%4], s[3]);
        end
        return r;
    endfunction

endpackage

// ===== rtl/aes_cbc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module aes_cbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 44
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/aes_cbc_round.sv =====
// ----------------------------------------------------------------------------
// AES round unit
// Shared round datapath: one encrypt or decrypt round a cycle, with the round
// key arriving from the round key store as one 128-bit word a cycle.
// ----------------------------------------------------------------------------
module aes_cbc_round
    import aes_cbc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  round_cmd_t   cmd,
    input  logic [127:0] round_key,
    output logic         busy,
    output logic         done,
    output logic [127:0] result
);

    logic [127:0] st_reg;
    logic [127:0] st_next;
    logic [3:0]   rnd_reg;
    logic         busy_reg;
    logic         dec_reg;
    logic         done_reg;
    logic [7:0]   b  [16];
    logic [7:0]   sh [16];
    logic [7:0]   sb [16];
    logic [127:0] sbw;
    logic [127:0] mx;
    logic         last;

    assign last = (rnd_reg == 4'(NUM_ROUNDS));

    always_comb
    begin
        for (int i = 0; i < 16; i++) b[i] = st_reg[127-8*i -: 8];
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (dec_reg) sh[r+4*c] = b[r+4*((c-r+4)%4)];
                else         sh[r+4*c] = b[r+4*((c+r)%4)];
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            sb[i] = dec_reg ? inv_sbox(sh[i]) : sbox(sh[i]);
            sbw[127-8*i -: 8] = sb[i];
        end
        for (int c = 0; c < 4; c++)
        begin
            if (dec_reg) mx[127-32*c -: 32] = mix_col(sbw[127-32*c -: 32] ^
                                                      round_key[127-32*c -: 32], 1'b1);
            else         mx[127-32*c -: 32] = mix_col(sbw[127-32*c -: 32], 1'b0) ^
                                                      round_key[127-32*c -: 32];
        end
        if (last) st_next = sbw ^ round_key;
        else      st_next = mx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rnd_reg  <= '0;
            done_reg <= 1'b0;
            dec_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= 4'd1;
                dec_reg  <= cmd.decrypt;
            end
            else if (busy_reg)
            begin
                rnd_reg <= rnd_reg + 4'd1;
                if (last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)          st_reg <= cmd.state ^ round_key;
        else if (busy_reg)      st_reg <= st_next;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = st_reg;

endmodule

// ===== rtl/aes128_cbc_cipher_core.sv =====
// ----------------------------------------------------------------------------
// AES-128 CBC cipher core
// Encrypts or decrypts one 128-bit word per request with CBC chaining.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_ready, in_data) takes one block word with a
// first-block flag that reloads the chain from the IV registers. The output
// channel (out_valid, out_ready, out_data) returns one result word per input.
// Registers are written through cfg_we, cfg_index and cfg_data, only while
// idle: the user must keep to this, as the core itself does not enforce it.
// After a key write the next block first expands the key schedule, one 32-bit
// word per cycle, kept as one 128-bit round key per entry of the key RAM.
// A block then passes the fetch state, which starts the round key reads and
// the round unit, then the ten rounds and the capture of the result into the
// output register, after which out_valid rises. The single round unit runs
// one round a cycle, and the core takes no new block until the result has
// been taken, so a stalled receiver holds the core. Reset clears the control
// state, the registers and the chain, and marks the key schedule stale.
// ----------------------------------------------------------------------------
module aes128_cbc_cipher_core
    import aes_cbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_word_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_word_t  out_data,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [63:0] cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXPAND = 3'd1;
    localparam logic [2:0] S_FETCH  = 3'd2;
    localparam logic [2:0] S_ROUND  = 3'd3;
    localparam logic [2:0] S_OUT    = 3'd4;

    logic [2:0]   st_reg;
    logic [63:0]  key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    logic         dec_reg;
    logic         stale_reg;
    logic [127:0] chain_reg;
    logic [127:0] blk_reg;
    logic [127:0] out_reg;
    logic [5:0]   widx_reg;
    logic [31:0]  w_hist [4];
    logic [31:0]  wnew;
    logic [127:0] rk_wdata;
    logic [31:0]  rot;
    logic [7:0]   rcon;
    logic         ram_we;
    logic [3:0]   raddr_reg;
    logic [127:0] rdata;
    logic [2:0]   kcnt_reg;
    logic         rd_dec;
    round_cmd_t   cmd;
    logic         busy;
    logic         done;
    logic [127:0] result;
    logic [127:0] chain_use;

    aes_cbc_ram #(.WIDTH(128), .DEPTH(NUM_ROUNDS + 1)) u_keys (
        .clk   (clk),
        .we    (ram_we),
        .waddr (widx_reg[5:2]),
        .wdata (rk_wdata),
        .raddr (raddr_reg),
        .rdata (rdata)
    );

    aes_cbc_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .round_key (rdata),
        .busy      (busy),
        .done      (done),
        .result    (result)
    );

    always_comb
    begin
        rot = {w_hist[3][23:0], w_hist[3][31:24]};
        unique case (widx_reg[5:2])
            4'd1:    rcon = 8'h01;
            4'd2:    rcon = 8'h02;
            4'd3:    rcon = 8'h04;
            4'd4:    rcon = 8'h08;
            4'd5:    rcon = 8'h10;
            4'd6:    rcon = 8'h20;
            4'd7:    rcon = 8'h40;
            4'd8:    rcon = 8'h80;
            4'd9:    rcon = 8'h1b;
            4'd10:   rcon = 8'h36;
            default: rcon = 8'h00;
        endcase
        if (widx_reg < 6'd4)
        begin
            unique case (widx_reg[1:0])
                2'd0:    wnew = key_high_reg[63:32];
                2'd1:    wnew = key_high_reg[31:0];
                2'd2:    wnew = key_low_reg[63:32];
                default: wnew = key_low_reg[31:0];
            endcase
        end
        else if (widx_reg[1:0] == 2'd0)
        begin
            wnew = w_hist[0] ^ {sbox(rot[31:24]) ^ rcon, sbox(rot[23:16]),
                                sbox(rot[15:8]), sbox(rot[7:0])};
        end
        else
        begin
            wnew = w_hist[0] ^ w_hist[3];
        end
    end

    assign rk_wdata = {w_hist[1], w_hist[2], w_hist[3], wnew};
    assign ram_we = (st_reg == S_EXPAND) && (widx_reg[1:0] == 2'd3);
    assign chain_use = in_data.first_block ? {iv_high_reg, iv_low_reg} : chain_reg;
    assign rd_dec = dec_reg;

    always_comb
    begin
        cmd.start   = (st_reg == S_FETCH) && (kcnt_reg == 3'd1);
        cmd.decrypt = dec_reg;
        cmd.state   = blk_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= S_IDLE;
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
            dec_reg      <= 1'b0;
            stale_reg    <= 1'b1;
            chain_reg    <= '0;
            widx_reg     <= '0;
            kcnt_reg     <= '0;
            raddr_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_KEY_HIGH: begin key_high_reg <= cfg_data; stale_reg <= 1'b1; end
                    REG_KEY_LOW:  begin key_low_reg <= cfg_data; stale_reg <= 1'b1; end
                    REG_IV_HIGH:  iv_high_reg <= cfg_data;
                    REG_IV_LOW:   iv_low_reg <= cfg_data;
                    REG_DECRYPT:  dec_reg <= cfg_data[0];
                    default:      ;
                endcase
            end
            unique case (st_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (dec_reg) chain_reg <= {in_data.block_in_high, in_data.block_in_low};
                        widx_reg <= '0;
                        kcnt_reg <= '0;
                        raddr_reg <= dec_reg ? 4'(NUM_ROUNDS) : 4'd0;
                        st_reg   <= stale_reg ? S_EXPAND : S_FETCH;
                    end
                end
                S_EXPAND:
                begin
                    widx_reg <= widx_reg + 6'd1;
                    if (widx_reg == 6'(NUM_WORDS - 1))
                    begin
                        stale_reg <= 1'b0;
                        st_reg    <= S_FETCH;
                    end
                end
                S_FETCH:
                begin
                    raddr_reg <= rd_dec ? raddr_reg - 4'd1 : raddr_reg + 4'd1;
                    if (kcnt_reg == 3'd1)
                    begin
                        kcnt_reg <= '0;
                        st_reg   <= S_ROUND;
                    end
                    else
                    begin
                        kcnt_reg <= kcnt_reg + 3'd1;
                    end
                end
                S_ROUND:
                begin
                    // The key of the next round is read ahead of that round.
                    if (rd_dec ? (raddr_reg != 4'd0) : (raddr_reg != 4'(NUM_ROUNDS)))
                        raddr_reg <= rd_dec ? raddr_reg - 4'd1 : raddr_reg + 4'd1;
                    if (done)
                    begin
                        st_reg <= S_OUT;
                        if (!dec_reg) chain_reg <= result;
                    end
                end
                S_OUT:
                begin
                    if (out_ready) st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers: block capture, history for expansion and result capture.
    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && in_valid)
        begin
            blk_reg <= dec_reg ? {in_data.block_in_high, in_data.block_in_low}
                               : {in_data.block_in_high, in_data.block_in_low} ^ chain_use;
            out_reg <= chain_use;
        end
        if (st_reg == S_EXPAND)
        begin
            w_hist[0] <= w_hist[1];
            w_hist[1] <= w_hist[2];
            w_hist[2] <= w_hist[3];
            w_hist[3] <= wnew;
        end
        if (st_reg == S_ROUND && done && dec_reg)
            out_reg <= result ^ out_reg;
        else if (st_reg == S_ROUND && done)
            out_reg <= result;
    end

    assign in_ready  = (st_reg == S_IDLE);
    assign out_valid = (st_reg == S_OUT);
    assign out_data.block_out_high = out_reg[127:64];
    assign out_data.block_out_low  = out_reg[63:0];

    a_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ready) else $error("round unit busy while accepting");
    a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> out_valid) else $error("result not presented after last round");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !busy) else $error("round start while busy");

endmodule

// ===== verif/aes128_cbc_cipher_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 CBC cipher core testbench
// Drives blocks through the core in both directions under several key, IV
// and mode settings with random idle and stall patterns. An AES-128 CBC
// predictor in the scoreboard works out each result, which is compared field
// by field with the word that the core returns.
// ----------------------------------------------------------------------------
module aes128_cbc_cipher_core_tb;
    import aes_cbc_pkg::*;

    class cbc_scoreboard;
        logic [7:0]  sub_fwd [256];
        logic [7:0]  sub_inv [256];
        logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
        logic        decrypt;
        logic [63:0] chain_hi, chain_lo;
        logic [31:0] rkey [44];
        bit          keys_old;
        out_word_t   pending_blocks [$];
        int          mismatches;
        int          checked;

        function new();
            logic [7:0] p, q, x;
            p = 8'h01;
            q = 8'h01;
            // Build the S-box by walking the multiplicative group with generator 3.
            do
            begin
                p = p ^ {p[6:0], 1'b0} ^ (p[7] ? 8'h1b : 8'h00);
                q = q ^ (q << 1);
                q = q ^ (q << 2);
                q = q ^ (q << 4);
                if (q[7])
                    q = q ^ 8'h09;
                x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]}
                    ^ {q[3:0], q[7:4]} ^ 8'h63;
                sub_fwd[p] = x;
                sub_inv[x] = p;
            end
            while (p != 8'h01);
            sub_fwd[0] = 8'h63;
            sub_inv[8'h63] = 8'h00;
            key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
            decrypt = 1'b0;
            chain_hi = '0; chain_lo = '0;
            keys_old = 1'b1;
            mismatches = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] val);
            case (idx)
                REG_KEY_HIGH: begin key_hi = val; keys_old = 1'b1; end
                REG_KEY_LOW:  begin key_lo = val; keys_old = 1'b1; end
                REG_IV_HIGH:  iv_hi = val;
                REG_IV_LOW:   iv_lo = val;
                REG_DECRYPT:  decrypt = val[0];
                default: ;
            endcase
        endfunction

        function logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
            logic [7:0] prod;
            prod = 8'h00;
            for (int i = 0; i < 8; i++)
            begin
                if (b[i])
                    prod = prod ^ a;
                a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            end
            return prod;
        endfunction

        function void schedule_keys();
            logic [31:0] t;
            logic [7:0]  rc;
            rkey[0] = key_hi[63:32]; rkey[1] = key_hi[31:0];
            rkey[2] = key_lo[63:32]; rkey[3] = key_lo[31:0];
            rc = 8'h01;
            for (int i = 4; i < 44; i++)
            begin
                t = rkey[i-1];
                if (i % 4 == 0)
                begin
                    t = {t[23:0], t[31:24]};
                    t = {sub_fwd[t[31:24]], sub_fwd[t[23:16]], sub_fwd[t[15:8]],
                         sub_fwd[t[7:0]]} ^ {rc, 24'h0};
                    rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
                end
                rkey[i] = rkey[i-4] ^ t;
            end
            keys_old = 1'b0;
        endfunction

        function logic [127:0] round_trip(logic [127:0] blk, bit inv);
            logic [7:0] s [16];
            logic [7:0] t [16];
            logic [7:0] fm [4];
            logic [7:0] im [4];
            int r;
            fm = '{8'h02, 8'h03, 8'h01, 8'h01};
            im = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
            for (int i = 0; i < 16; i++)
                s[i] = blk[127-8*i -: 8];
            for (int step = 0; step <= 10; step++)
            begin
                r = inv ? 10 - step : step;
                if (step > 0)
                begin
                    for (int row = 0; row < 4; row++)
                        for (int c = 0; c < 4; c++)
                            t[row+4*c] = s[row + 4*(inv ? (c-row+4)%4 : (c+row)%4)];
                    for (int i = 0; i < 16; i++)
                        s[i] = inv ? sub_inv[t[i]] : sub_fwd[t[i]];
                    if (!inv && step != 10)
                        for (int c = 0; c < 4; c++)
                            for (int row = 0; row < 4; row++)
                            begin
                                t[c*4+row] = 8'h00;
                                for (int k = 0; k < 4; k++)
                                    t[c*4+row] ^= gmul(fm[(k-row+4)%4], s[c*4+k]);
                            end
                    else
                        t = s;
                    s = t;
                end
                for (int i = 0; i < 16; i++)
                    s[i] ^= rkey[r*4 + i/4][31-8*(i%4) -: 8];
                if (inv && step > 0 && step != 10)
                begin
                    for (int c = 0; c < 4; c++)
                        for (int row = 0; row < 4; row++)
                        begin
                            t[c*4+row] = 8'h00;
                            for (int k = 0; k < 4; k++)
                                t[c*4+row] ^= gmul(im[(k-row+4)%4], s[c*4+k]);
                        end
                    s = t;
                end
            end
            for (int i = 0; i < 16; i++)
                blk[127-8*i -: 8] = s[i];
            return blk;
        endfunction

        function void note_block(in_word_t w);
            logic [127:0] res;
            out_word_t o;
            if (keys_old)
                schedule_keys();
            if (w.first_block)
            begin
                chain_hi = iv_hi;
                chain_lo = iv_lo;
            end
            if (decrypt)
            begin
                res = round_trip({w.block_in_high, w.block_in_low}, 1'b1)
                      ^ {chain_hi, chain_lo};
                chain_hi = w.block_in_high;
                chain_lo = w.block_in_low;
            end
            else
            begin
                res = round_trip({w.block_in_high ^ chain_hi, w.block_in_low ^ chain_lo},
                                 1'b0);
                {chain_hi, chain_lo} = res;
            end
            o.block_out_high = res[127:64];
            o.block_out_low = res[63:0];
            pending_blocks = {pending_blocks, o};
        endfunction

        function void check_block(out_word_t got);
            out_word_t exp_w;
            if (pending_blocks.size() == 0)
            begin
                $display("%0t: unexpected word %h", $realtime, got);
                mismatches++;
                return;
            end
            exp_w = pending_blocks.pop_front();
            checked++;
            if (got.block_out_high !== exp_w.block_out_high)
            begin
                $display("%0t: block_out_high expected %h actual %h", $realtime,
                         exp_w.block_out_high, got.block_out_high);
                mismatches++;
            end
            if (got.block_out_low !== exp_w.block_out_low)
            begin
                $display("%0t: block_out_low expected %h actual %h", $realtime,
                         exp_w.block_out_low, got.block_out_low);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_word_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_word_t   out_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    cbc_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int sent_blocks;
    int dec_blocks;

    aes128_cbc_cipher_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #50_000_000;
        $display("simulation failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            sb.note_block(in_data);
            sent_blocks++;
            if (sb.decrypt)
                dec_blocks++;
        end
        if (rst_n && out_valid && out_ready)
            sb.check_block(out_data);
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.write_reg(idx, val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_block(logic [63:0] hi, logic [63:0] lo, logic first);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data <= '{block_in_high: hi, block_in_low: lo, first_block: first};
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_blocks.size() != 0)
            @(posedge clk);
        repeat (80)
            @(posedge clk);
    endtask

    task automatic setup(logic [63:0] kh, logic [63:0] kl, logic [63:0] ih,
                         logic [63:0] il, logic dec);
        drain();
        write_reg(REG_KEY_HIGH, kh);
        write_reg(REG_KEY_LOW, kl);
        write_reg(REG_IV_HIGH, ih);
        write_reg(REG_IV_LOW, il);
        write_reg(REG_DECRYPT, {63'b0, dec});
    endtask

    task automatic random_message(int len);
        for (int i = 0; i < len; i++)
            send_block(rand64(), rand64(), i == 0 || $urandom_range(15) == 0);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = REG_KEY_HIGH;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        sent_blocks = 0;
        dec_blocks = 0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;

        send_block('0, '0, 1'b0);
        send_block('1, '1, 1'b0);
        setup(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 64'h0001020304050607,
              64'h08090a0b0c0d0e0f, 1'b0);
        send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 1'b1);
        send_block(64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 1'b0);
        drain();
        write_reg(REG_DECRYPT, 64'd1);
        send_block(64'h7649abac8119b246, 64'hcee98e9b12e9197d, 1'b1);
        send_block(64'h5086cb9b507219ee, 64'h95db113a917678b2, 1'b0);
        setup('1, '1, '1, '1, 1'b1);
        send_block('1, '1, 1'b1);
        send_block('0, '0, 1'b0);
        drain();
        write_reg(REG_DECRYPT, 64'd0);
        send_block('1, '0, 1'b0);
        send_block('0, '1, 1'b1);
        drain();
        write_reg(3'd5, '1);
        write_reg(3'd7, '1);
        write_reg(REG_DECRYPT, 64'hfffffffffffffffe);
        send_block(64'h8000000000000000, 64'h1, 1'b0);
        drain();
        write_reg(REG_KEY_LOW, rand64());
        send_block(rand64(), rand64(), 1'b0);

        for (int ph = 0; ph < 8; ph++)
        begin
            send_idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 3 ? 28 : 54) : 0;
            recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 3 ? 28 : 54) : 0;
            setup(rand64(), rand64(), rand64(), rand64(), ph[0] ^ ph[2]);
            if (ph == 4)
                hold_cycles = 2000;
            for (int m = 0; m < 23; m++)
            begin
                if (m == 11)
                begin
                    drain();
                    write_reg(REG_DECRYPT, {63'b0, ~sb.decrypt});
                    if (m[0])
                        write_reg(REG_KEY_HIGH, rand64());
                end
                random_message($urandom_range(1, 19));
            end
        end
        drain();
        $display("Covered %0d blocks (%0d decrypted) and %0d results over eight settings.",
                 sent_blocks, dec_blocks, sb.checked);
        $display("Idle and stall patterns included a long receiver hold-off.");
        if (sb.mismatches == 0 && sb.pending_blocks.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
